@@ design/hsc_pkg.sv @@
// shared types, codes and byte tables of the hmp to smf converter
package hsc_pkg;

    localparam logic [2:0] BK_NONE   = 3'd0;
    localparam logic [2:0] BK_SINGLE = 3'd1;
    localparam logic [2:0] BK_HEADER = 3'd2;
    localparam logic [2:0] BK_MTRK   = 3'd3;
    localparam logic [2:0] BK_DELTA  = 3'd4;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_PATCH = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] ERR_SIGNATURE = 3'd1;
    localparam logic [2:0] ERR_TRACK_NUM = 3'd2;
    localparam logic [2:0] ERR_EOT_SIZE  = 3'd3;
    localparam logic [2:0] ERR_COMMAND   = 3'd4;
    localparam logic [2:0] ERR_LENGTH    = 3'd5;
    localparam logic [2:0] ERR_VLQ       = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED = 3'd7;

    localparam logic [5:0] HEADER_BYTES = 6'd33;
    localparam logic [5:0] MTRK_BYTES   = 6'd8;

    typedef struct packed {
        logic [2:0]  bk;
        logic [15:0] data;
        logic        patch;
        logic [31:0] poff;
        logic [31:0] plen;
        logic        done;
        logic [31:0] total;
        logic        err;
        logic [2:0]  ecode;
    } cmd_t;

    function automatic logic [7:0] sig_byte(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0: r = "H";
            3'd1: r = "M";
            3'd2: r = "I";
            3'd3: r = "M";
            3'd4: r = "I";
            3'd5: r = "D";
            3'd6: r = "I";
            default: r = "P";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] header_byte(input logic [5:0] i, input logic [15:0] tc);
        logic [7:0] r;
        case (i)
            6'd0:  r = "M";
            6'd1:  r = "T";
            6'd2:  r = "h";
            6'd3:  r = "d";
            6'd7:  r = 8'h06;
            6'd9:  r = 8'h01;
            6'd10: r = tc[15:8];
            6'd11: r = tc[7:0];
            6'd13: r = 8'hC0;
            6'd14: r = "M";
            6'd15: r = "T";
            6'd16: r = "r";
            6'd17: r = "k";
            6'd21: r = 8'h0B;
            6'd23: r = 8'hFF;
            6'd24: r = 8'h51;
            6'd25: r = 8'h03;
            6'd26: r = 8'h18;
            6'd27: r = 8'h80;
            6'd30: r = 8'hFF;
            6'd31: r = 8'h2F;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] mtrk_byte(input logic [5:0] i);
        logic [7:0] r;
        case (i)
            6'd0: r = "M";
            6'd1: r = "T";
            6'd2: r = "r";
            6'd3: r = "k";
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ design/hsc_front.sv @@
// front end: parses hmp bytes and issues output commands
module hsc_front
    import hsc_pkg::*;
#(
    parameter int MAX_DELTA_BYTES = 4,
    parameter int DCW = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_byte,
    input  logic                         start_req,
    input  logic                         final_byte,
    input  logic                         full,
    output logic                         push,
    output cmd_t                         cmd,
    output logic [DCW-1:0]               cmd_k,
    output logic [MAX_DELTA_BYTES*7-1:0] cmd_dig
);

    localparam logic [3:0] PH_WAIT   = 4'd0;
    localparam logic [3:0] PH_PRE    = 4'd1;
    localparam logic [3:0] PH_SCAN   = 4'd2;
    localparam logic [3:0] PH_THDR   = 4'd3;
    localparam logic [3:0] PH_DELTA  = 4'd4;
    localparam logic [3:0] PH_STATUS = 4'd5;
    localparam logic [3:0] PH_DATA   = 4'd6;
    localparam logic [3:0] PH_MTYPE  = 4'd7;
    localparam logic [3:0] PH_MLEN   = 4'd8;
    localparam logic [3:0] PH_MDATA  = 4'd9;

    logic [3:0]  phase_reg, phase_next;
    logic [9:0]  fpos_reg, fpos_next;
    logic [31:0] tcount_reg, tcount_next;
    logic [31:0] tidx_reg, tidx_next;
    logic [31:0] hword_reg, hword_next;
    logic [31:0] tleft_reg, tleft_next;
    logic [31:0] opos_reg, opos_next;
    logic [31:0] lwpos_reg, lwpos_next;
    logic [MAX_DELTA_BYTES*7-1:0] dig_reg, dig_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic [7:0]  prev_reg, prev_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [7:0]  ebl_reg, ebl_next;
    logic [15:0] scan_reg, scan_next;
    logic        past_reg, past_next;

    logic        ev_end, ev_eot, tr_end;
    logic [5:0]  nb;
    logic [31:0] op_after;
    logic [3:0]  p;
    logic [7:0]  hi;

    assign in_ready = !full;

    always_comb
    begin
        phase_next  = start_req ? PH_PRE : phase_reg;
        fpos_next   = start_req ? '0 : fpos_reg;
        tcount_next = start_req ? '0 : tcount_reg;
        tidx_next   = start_req ? '0 : tidx_reg;
        hword_next  = start_req ? '0 : hword_reg;
        tleft_next  = start_req ? '0 : tleft_reg;
        opos_next   = start_req ? '0 : opos_reg;
        lwpos_next  = start_req ? '0 : lwpos_reg;
        dig_next    = dig_reg;
        dcnt_next   = start_req ? '0 : dcnt_reg;
        prev_next   = start_req ? '0 : prev_reg;
        mtype_next  = start_req ? '0 : mtype_reg;
        ebl_next    = start_req ? '0 : ebl_reg;
        scan_next   = start_req ? '0 : scan_reg;
        past_next   = start_req ? 1'b0 : past_reg;
        cmd         = '0;
        cmd.bk      = BK_NONE;
        cmd.data    = {8'h00, in_byte};
        cmd_k       = dcnt_next;
        cmd_dig     = dig_next;
        ev_end      = 1'b0;
        ev_eot      = 1'b0;
        tr_end      = 1'b0;
        p           = fpos_next[3:0];
        hi          = in_byte & 8'hF0;

        case (phase_next)
            PH_PRE:
            begin
                if (fpos_next < 10'd8)
                begin
                    if (in_byte != sig_byte(fpos_next[2:0]))
                    begin
                        cmd.err = 1'b1; cmd.ecode = ERR_SIGNATURE; phase_next = PH_WAIT;
                    end
                    else
                        fpos_next = fpos_next + 10'd1;
                end
                else if (fpos_next >= 10'h300)
                begin
                    if (!final_byte)
                    begin
                        cmd.bk = BK_HEADER;
                        cmd.data = tcount_next[15:0];
                    end
                    scan_next = {8'h00, in_byte};
                    phase_next = PH_SCAN;
                end
                else
                begin
                    if (fpos_next >= 10'h030 && fpos_next < 10'h034)
                    begin
                        if (fpos_next == 10'h030)
                            hword_next = '0;
                        case (fpos_next[1:0])
                            2'd0: hword_next[7:0] = in_byte;
                            2'd1: hword_next[15:8] = in_byte;
                            2'd2: hword_next[23:16] = in_byte;
                            default: hword_next[31:24] = in_byte;
                        endcase
                        if (fpos_next == 10'h033)
                            tcount_next = hword_next;
                    end
                    fpos_next = fpos_next + 10'd1;
                end
            end
            PH_SCAN:
            begin
                if (scan_next == 16'hFF2F && in_byte == 8'h00)
                begin
                    if (tcount_next < 32'd2)
                    begin
                        cmd.done = 1'b1; cmd.total = opos_next; phase_next = PH_WAIT;
                    end
                    else
                    begin
                        tidx_next = 32'd1; fpos_next = '0; phase_next = PH_THDR;
                    end
                end
                else
                    scan_next = {scan_next[7:0], in_byte};
            end
            PH_THDR:
            begin
                if (p < 4'd8)
                begin
                    if (p[1:0] == 2'd0)
                        hword_next = '0;
                    case (p[1:0])
                        2'd0: hword_next[7:0] = in_byte;
                        2'd1: hword_next[15:8] = in_byte;
                        2'd2: hword_next[23:16] = in_byte;
                        default: hword_next[31:24] = in_byte;
                    endcase
                end
                if (p == 4'd3 && hword_next != tidx_next)
                begin
                    cmd.err = 1'b1; cmd.ecode = ERR_TRACK_NUM; phase_next = PH_WAIT;
                end
                else if (p == 4'd7 && hword_next < 32'd12)
                begin
                    cmd.err = 1'b1; cmd.ecode = ERR_LENGTH; phase_next = PH_WAIT;
                end
                else
                begin
                    if (p == 4'd7)
                        tleft_next = hword_next - 32'd12;
                    if (p >= 4'd11)
                    begin
                        cmd.bk = BK_MTRK;
                        lwpos_next = opos_next + 32'd4;
                        prev_next = '0;
                        past_next = 1'b0;
                        if (tleft_next == '0)
                            tr_end = 1'b1;
                        else
                        begin
                            phase_next = PH_DELTA; dcnt_next = '0;
                        end
                    end
                    else
                        fpos_next = {6'd0, p + 4'd1};
                end
            end
            PH_DELTA, PH_STATUS, PH_DATA, PH_MTYPE, PH_MLEN, PH_MDATA:
            begin
                if (tleft_next == '0)
                    past_next = 1'b1;
                else
                    tleft_next = tleft_next - 32'd1;
                case (phase_next)
                    PH_DELTA:
                    begin
                        if (in_byte[7])
                        begin
                            cmd.bk = BK_DELTA;
                            phase_next = PH_STATUS;
                        end
                        else if (32'(dcnt_next) + 32'd1 >= 32'(MAX_DELTA_BYTES))
                        begin
                            cmd.err = 1'b1; cmd.ecode = ERR_VLQ; phase_next = PH_WAIT;
                        end
                        else
                        begin
                            dig_next[32'(dcnt_next)*7 +: 7] = in_byte[6:0];
                            dcnt_next = dcnt_next + DCW'(1);
                        end
                    end
                    PH_STATUS:
                    begin
                        if (in_byte == 8'hFF)
                        begin
                            cmd.bk = BK_SINGLE; phase_next = PH_MTYPE;
                        end
                        else if (hi inside {8'h80, 8'h90, 8'hA0, 8'hB0, 8'hE0, 8'hC0, 8'hD0})
                        begin
                            ebl_next = (hi == 8'hC0 || hi == 8'hD0) ? 8'd1 : 8'd2;
                            if (in_byte != prev_next)
                                cmd.bk = BK_SINGLE;
                            prev_next = in_byte;
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            cmd.err = 1'b1; cmd.ecode = ERR_COMMAND; phase_next = PH_WAIT;
                        end
                    end
                    PH_MTYPE:
                    begin
                        mtype_next = in_byte; cmd.bk = BK_SINGLE; phase_next = PH_MLEN;
                    end
                    PH_MLEN:
                    begin
                        if (mtype_next == 8'h2F && in_byte != 8'h00)
                        begin
                            cmd.err = 1'b1; cmd.ecode = ERR_EOT_SIZE; phase_next = PH_WAIT;
                        end
                        else
                        begin
                            cmd.bk = BK_SINGLE;
                            ebl_next = in_byte;
                            if (in_byte == 8'h00)
                            begin
                                ev_end = 1'b1; ev_eot = (mtype_next == 8'h2F);
                            end
                            else
                                phase_next = PH_MDATA;
                        end
                    end
                    default:
                    begin
                        cmd.bk = BK_SINGLE;
                        ebl_next = ebl_next - 8'd1;
                        if (ebl_next == 8'd0)
                            ev_end = 1'b1;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        case (cmd.bk)
            BK_SINGLE: nb = 6'd1;
            BK_HEADER: nb = HEADER_BYTES;
            BK_MTRK:   nb = MTRK_BYTES;
            BK_DELTA:  nb = 6'(dcnt_next) + 6'd1;
            default:   nb = 6'd0;
        endcase
        op_after = opos_next + {26'd0, nb};
        opos_next = op_after;

        if (ev_end)
        begin
            if (ev_eot || past_next || tleft_next == '0)
                tr_end = 1'b1;
            else
            begin
                phase_next = PH_DELTA; dcnt_next = '0;
            end
        end
        if (tr_end)
        begin
            if (past_next || tleft_next != '0)
            begin
                cmd.err = 1'b1; cmd.ecode = ERR_LENGTH; phase_next = PH_WAIT;
            end
            else
            begin
                cmd.patch = 1'b1;
                cmd.poff = lwpos_next;
                cmd.plen = op_after - lwpos_next - 32'd4;
                tidx_next = tidx_next + 32'd1;
                if (tidx_next >= tcount_next)
                begin
                    cmd.done = 1'b1; cmd.total = op_after; phase_next = PH_WAIT;
                end
                else
                begin
                    phase_next = PH_THDR; fpos_next = '0;
                end
            end
        end
        if (final_byte && phase_next != PH_WAIT)
        begin
            cmd.err = 1'b1; cmd.ecode = ERR_TRUNCATED; phase_next = PH_WAIT;
        end
        push = in_valid && !full && (cmd.bk != BK_NONE || cmd.patch || cmd.done || cmd.err);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            fpos_reg   <= '0;
            tcount_reg <= '0;
            tidx_reg   <= '0;
            hword_reg  <= '0;
            tleft_reg  <= '0;
            opos_reg   <= '0;
            lwpos_reg  <= '0;
            dcnt_reg   <= '0;
            prev_reg   <= '0;
            mtype_reg  <= '0;
            ebl_reg    <= '0;
            scan_reg   <= '0;
            past_reg   <= 1'b0;
        end
        else if (in_valid && !full)
        begin
            phase_reg  <= phase_next;
            fpos_reg   <= fpos_next;
            tcount_reg <= tcount_next;
            tidx_reg   <= tidx_next;
            hword_reg  <= hword_next;
            tleft_reg  <= tleft_next;
            opos_reg   <= opos_next;
            lwpos_reg  <= lwpos_next;
            dcnt_reg   <= dcnt_next;
            prev_reg   <= prev_next;
            mtype_reg  <= mtype_next;
            ebl_reg    <= ebl_next;
            scan_reg   <= scan_next;
            past_reg   <= past_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !full)
            dig_reg <= dig_next;
    end

endmodule

@@ design/hsc_fifo.sv @@
// short command queue between front end and back end
module hsc_fifo #(
    parameter int W = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         nonempty,
    output logic [W-1:0] rdata
);

    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW:0]   cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            if (pop)
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

@@ design/hsc_back.sv @@
// back end: expands queued commands into result words
module hsc_back
    import hsc_pkg::*;
#(
    parameter int MAX_DELTA_BYTES = 4,
    parameter int DCW = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         nonempty,
    input  cmd_t                         cmd,
    input  logic [DCW-1:0]               cmd_k,
    input  logic [MAX_DELTA_BYTES*7-1:0] cmd_dig,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [7:0]                   out_byte,
    output logic [31:0]                  patch_offset,
    output logic [31:0]                  patch_length,
    output logic [31:0]                  total_size,
    output logic [2:0]                   error_code,
    output logic                         run_end
);

    logic [5:0] idx_reg;
    logic [5:0] nb, n;
    logic       step, last;
    logic [DCW-1:0] pos;
    logic [1:0]  kind_c;
    logic [7:0]  byte_c;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [31:0] poff_reg, plen_reg, total_reg;
    logic [2:0]  ecode_reg;
    logic        end_reg;

    always_comb
    begin
        case (cmd.bk)
            BK_SINGLE: nb = 6'd1;
            BK_HEADER: nb = HEADER_BYTES;
            BK_MTRK:   nb = MTRK_BYTES;
            BK_DELTA:  nb = 6'(cmd_k) + 6'd1;
            default:   nb = 6'd0;
        endcase
        n = nb + 6'(cmd.patch) + 6'(cmd.done) + 6'(cmd.err);
        last = (idx_reg == n - 6'd1);
        step = nonempty && (!valid_reg || out_ready);
        pop = step && last;
        pos = cmd_k - idx_reg[DCW-1:0];
        byte_c = 8'h00;
        if (idx_reg < nb)
        begin
            kind_c = KIND_BYTE;
            case (cmd.bk)
                BK_HEADER: byte_c = header_byte(idx_reg, cmd.data);
                BK_MTRK:   byte_c = mtrk_byte(idx_reg);
                BK_DELTA:
                begin
                    if (idx_reg == 6'd0)
                        byte_c = {cmd_k != '0, cmd.data[6:0]};
                    else
                        byte_c = {pos != '0, cmd_dig[32'(pos)*7 +: 7]};
                end
                default:   byte_c = cmd.data[7:0];
            endcase
        end
        else if (cmd.patch && idx_reg == nb)
            kind_c = KIND_PATCH;
        else if (cmd.done && idx_reg == nb + 6'(cmd.patch))
            kind_c = KIND_DONE;
        else
            kind_c = KIND_ERROR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (step)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= last ? '0 : idx_reg + 6'd1;
        end
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            kind_reg  <= kind_c;
            byte_reg  <= byte_c;
            poff_reg  <= (kind_c == KIND_PATCH) ? cmd.poff : '0;
            plen_reg  <= (kind_c == KIND_PATCH) ? cmd.plen : '0;
            total_reg <= (kind_c == KIND_DONE) ? cmd.total : '0;
            ecode_reg <= (kind_c == KIND_ERROR) ? cmd.ecode : '0;
            end_reg   <= last;
        end
    end

    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = byte_reg;
    assign patch_offset = poff_reg;
    assign patch_length = plen_reg;
    assign total_size   = total_reg;
    assign error_code   = ecode_reg;
    assign run_end      = end_reg;

endmodule

@@ design/hmp_to_smf_converter.sv @@
// top level of the hmp to standard midi file converter
// Takes an HMP file one word per cycle and streams out a type-1 MIDI file as byte
// words plus length-patch, done and error words. The front end parses one input
// word per cycle and queues at most one command for it; the back end expands each
// command into its result words at one per cycle while the receiver is ready. Input
// keeps flowing until the command queue is full; the file header expands into 33 words.
// A command passes the queue and the back end's output register before it shows.
module hmp_to_smf_converter
    import hsc_pkg::*;
#(
    parameter int MAX_DELTA_BYTES = 4,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // in_byte
    input  logic [0:0]   s_axis_tuser,  // start_req
    input  logic         s_axis_tlast,  // final_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // out_byte, patch_offset, patch_length, total_size, error_code
    output logic [1:0]   m_axis_tuser,  // kind
    output logic         m_axis_tlast   // run_end
);

    localparam int DCW = (MAX_DELTA_BYTES > 1) ? $clog2(MAX_DELTA_BYTES) : 1;
    localparam int QW = MAX_DELTA_BYTES * 7 + DCW + $bits(cmd_t);

    logic full, push, pop, nonempty;
    cmd_t f_cmd, b_cmd;
    logic [DCW-1:0] f_k, b_k;
    logic [MAX_DELTA_BYTES*7-1:0] f_dig, b_dig;
    logic [QW-1:0] rdata;
    logic [7:0] ob;
    logic [31:0] poff, plen, tot;
    logic [2:0] ec;

    hsc_front #(.MAX_DELTA_BYTES(MAX_DELTA_BYTES), .DCW(DCW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_byte(s_axis_tdata), .start_req(s_axis_tuser[0]), .final_byte(s_axis_tlast),
        .full(full), .push(push), .cmd(f_cmd), .cmd_k(f_k), .cmd_dig(f_dig)
    );

    hsc_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(push), .wdata({f_dig, f_k, f_cmd}), .full(full),
        .pop(pop), .nonempty(nonempty), .rdata(rdata)
    );

    assign {b_dig, b_k, b_cmd} = rdata;

    hsc_back #(.MAX_DELTA_BYTES(MAX_DELTA_BYTES), .DCW(DCW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .nonempty(nonempty), .cmd(b_cmd), .cmd_k(b_k), .cmd_dig(b_dig), .pop(pop),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .kind(m_axis_tuser), .out_byte(ob), .patch_offset(poff), .patch_length(plen),
        .total_size(tot), .error_code(ec), .run_end(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, ec, tot, plen, poff, ob};

endmodule

@@ tb/sv/tb.sv @@
// testbench for the hmp to standard midi file converter
`timescale 1ns / 100ps

module tb;
    import hsc_pkg::*;

    typedef enum int {
        ST_WAIT, ST_PRE, ST_SCAN, ST_THDR, ST_DELTA, ST_STATUS, ST_DATA,
        ST_MTYPE, ST_MLEN, ST_MDATA
    } stage_e;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  ob;
        logic [31:0] poff;
        logic [31:0] plen;
        logic [31:0] tot;
        logic [2:0]  code;
        logic        last;
    } midi_word_t;

    typedef struct {
        logic [7:0] b;
        logic       st;
        logic       fin;
    } hmp_word_t;

    typedef struct {
        logic [7:0] b;
        logic       st;
        logic       fin;
        int         known_n;
        logic [1:0] kind;
        logic [2:0] code;
    } row_t;

    localparam int DELTA_MAX = 4;
    localparam logic [7:0] SIG [8] = '{"H", "M", "I", "M", "I", "D", "I", "P"};
    localparam logic [7:0] HEAD_A [10] = '{"M", "T", "h", "d", 0, 0, 0, 6, 0, 1};
    localparam logic [7:0] HEAD_B [21] = '{0, 8'hC0, "M", "T", "r", "k", 0, 0, 0, 8'h0B, 0,
        8'hFF, 8'h51, 8'h03, 8'h18, 8'h80, 0, 0, 8'hFF, 8'h2F, 0};
    localparam logic [7:0] TAG [4] = '{"M", "T", "r", "k"};

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    hmp_to_smf_converter DUT (.*);

    // converter state mirror
    stage_e      stg;
    logic [31:0] fpos, tcount, tidx, hword, trk_left, out_pos, lw_pos;
    logic [6:0]  digits [DELTA_MAX];
    logic [31:0] dcnt;
    logic [7:0]  prev_status, mtype, ev_left;
    logic [15:0] scan;
    logic        past_end;

    midi_word_t  step_q [$];
    midi_word_t  midi_q [$];
    hmp_word_t   stim_q [$];
    row_t        row_q [$];
    int          known_q [$];
    int          errors = 0;
    int          hold_cycles = 0;
    bit          stim_done = 0;

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #8ms;
        $display("** hmp_to_smf_converter: FAILED **");
        $finish;
    end

    task automatic clear_state();
        stg = ST_WAIT;
        fpos = 0; tcount = 0; tidx = 0; hword = 0; trk_left = 0;
        out_pos = 0; lw_pos = 0; dcnt = 0;
        prev_status = 0; mtype = 0; ev_left = 0; scan = 0; past_end = 0;
    endtask

    task automatic emit(logic [1:0] k, logic [7:0] b, logic [31:0] off, logic [31:0] len,
                        logic [31:0] tot, logic [2:0] code);
        midi_word_t w;
        if (step_q.size() >= 33)
            return;
        w = '{k, b, off, len, tot, code, 1'b0};
        step_q.push_back(w);
        if (k == KIND_BYTE)
            out_pos++;
    endtask

    task automatic emit_byte(logic [7:0] b);
        emit(KIND_BYTE, b, 0, 0, 0, 0);
    endtask

    task automatic raise(logic [2:0] code);
        emit(KIND_ERROR, 0, 0, 0, 0, code);
        stg = ST_WAIT;
    endtask

    task automatic close_track();
        if (past_end || trk_left != 0)
        begin
            raise(ERR_LENGTH);
            return;
        end
        emit(KIND_PATCH, 0, lw_pos, out_pos - lw_pos - 4, 0, 0);
        tidx++;
        if (tidx >= tcount)
        begin
            emit(KIND_DONE, 0, 0, 0, out_pos, 0);
            stg = ST_WAIT;
        end
        else
        begin
            stg = ST_THDR;
            fpos = 0;
        end
    endtask

    task automatic close_event(bit eot);
        if (eot || past_end || trk_left == 0)
            close_track();
        else
        begin
            stg = ST_DELTA;
            dcnt = 0;
        end
    endtask

    task automatic track_header(logic [7:0] b);
        logic [31:0] p;
        p = fpos & 32'hF;
        if (p < 8)
        begin
            if ((p & 3) == 0)
                hword = 0;
            hword |= 32'(b) << ((p & 3) * 8);
        end
        if (p == 3 && hword != tidx)
        begin
            raise(ERR_TRACK_NUM);
            return;
        end
        if (p == 7)
        begin
            if (hword < 12)
            begin
                raise(ERR_LENGTH);
                return;
            end
            trk_left = hword - 12;
        end
        if (p >= 11)
        begin
            for (int i = 0; i < 4; i++)
                emit_byte(TAG[i]);
            lw_pos = out_pos;
            for (int i = 0; i < 4; i++)
                emit_byte(8'h00);
            prev_status = 0;
            past_end = 0;
            if (trk_left == 0)
                close_track();
            else
            begin
                stg = ST_DELTA;
                dcnt = 0;
            end
            return;
        end
        fpos = p + 1;
    endtask

    task automatic track_event(logic [7:0] b);
        int k;
        logic [7:0] hi;
        if (trk_left == 0)
            past_end = 1;
        else
            trk_left--;
        case (stg)
            ST_DELTA:
            begin
                if (b[7])
                begin
                    k = (dcnt > DELTA_MAX - 1) ? DELTA_MAX - 1 : int'(dcnt);
                    emit_byte({k > 0, b[6:0]});
                    while (k > 0)
                    begin
                        k--;
                        emit_byte({k > 0, digits[k]});
                    end
                    stg = ST_STATUS;
                end
                else if (dcnt + 1 >= DELTA_MAX)
                    raise(ERR_VLQ);
                else
                begin
                    digits[dcnt] = b[6:0];
                    dcnt++;
                end
            end
            ST_STATUS:
            begin
                if (b == 8'hFF)
                begin
                    emit_byte(b);
                    stg = ST_MTYPE;
                end
                else
                begin
                    hi = b & 8'hF0;
                    if (hi inside {8'h80, 8'h90, 8'hA0, 8'hB0, 8'hE0})
                        ev_left = 2;
                    else if (hi inside {8'hC0, 8'hD0})
                        ev_left = 1;
                    else
                    begin
                        raise(ERR_COMMAND);
                        return;
                    end
                    if (b != prev_status)
                        emit_byte(b);
                    prev_status = b;
                    stg = ST_DATA;
                end
            end
            ST_MTYPE:
            begin
                mtype = b;
                emit_byte(b);
                stg = ST_MLEN;
            end
            ST_MLEN:
            begin
                if (mtype == 8'h2F && b != 0)
                begin
                    raise(ERR_EOT_SIZE);
                    return;
                end
                emit_byte(b);
                ev_left = b;
                if (b == 0)
                    close_event(mtype == 8'h2F);
                else
                    stg = ST_MDATA;
            end
            default:
            begin
                emit_byte(b);
                ev_left = ev_left - 1;
                if (ev_left == 0)
                    close_event(0);
            end
        endcase
    endtask

    task automatic convert_word(logic [7:0] b, logic st, logic fin);
        logic [31:0] p;
        step_q.delete();
        if (st)
        begin
            clear_state();
            stg = ST_PRE;
        end
        case (stg)
            ST_WAIT: ;
            ST_PRE:
            begin
                p = fpos;
                if (p < 8 && b != SIG[p])
                    raise(ERR_SIGNATURE);
                else if (p >= 32'h300)
                begin
                    if (!fin)
                    begin
                        foreach (HEAD_A[i])
                            emit_byte(HEAD_A[i]);
                        emit_byte(tcount[15:8]);
                        emit_byte(tcount[7:0]);
                        foreach (HEAD_B[i])
                            emit_byte(HEAD_B[i]);
                    end
                    scan = {8'h00, b};
                    stg = ST_SCAN;
                end
                else
                begin
                    if (p >= 32'h30 && p < 32'h34)
                    begin
                        if (p == 32'h30)
                            hword = 0;
                        hword |= 32'(b) << ((p - 32'h30) * 8);
                        if (p == 32'h33)
                            tcount = hword;
                    end
                    fpos = p + 1;
                end
            end
            ST_SCAN:
            begin
                if (scan == 16'hFF2F && b == 0)
                begin
                    if (tcount <= 1)
                    begin
                        emit(KIND_DONE, 0, 0, 0, out_pos, 0);
                        stg = ST_WAIT;
                    end
                    else
                    begin
                        tidx = 1;
                        fpos = 0;
                        stg = ST_THDR;
                    end
                end
                else
                    scan = {scan[7:0], b};
            end
            ST_THDR: track_header(b);
            default: track_event(b);
        endcase
        if (fin && stg != ST_WAIT)
            raise(ERR_TRUNCATED);
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1;
    endtask

    // predict on accepted input words, check accepted output words
    always @(posedge clk)
    begin
        midi_word_t e;
        int n;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            convert_word(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            n = known_q.size() ? known_q.pop_front() : -1;
            if (n == 0 && step_q.size() != 0)
            begin
                $display("%0t: expected no result, predictor gives %0d", $time, step_q.size());
                errors++;
            end
            if (n > 0)
            begin
                e = step_q[0];
                e.kind = row_q[0].kind;
                e.code = row_q[0].code;
                e.last = 1;
                midi_q.push_back(e);
            end
            else
                foreach (step_q[i])
                    midi_q.push_back(step_q[i]);
            if (n >= 0)
                void'(row_q.pop_front());
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (midi_q.size() == 0)
            begin
                $display("%0t: unexpected word kind %0d data %h", $time, m_axis_tuser,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                e = midi_q.pop_front();
                if (m_axis_tuser !== e.kind || m_axis_tdata[7:0] !== e.ob
                    || m_axis_tdata[39:8] !== e.poff || m_axis_tdata[71:40] !== e.plen
                    || m_axis_tdata[103:72] !== e.tot || m_axis_tdata[106:104] !== e.code
                    || m_axis_tdata[111:107] !== 5'd0 || m_axis_tlast !== e.last)
                begin
                    $display("%0t: expected kind %0d byte %h off %0d len %0d tot %0d err %0d last %0d",
                             $time, e.kind, e.ob, e.poff, e.plen, e.tot, e.code, e.last);
                    $display("%0t: actual   kind %0d byte %h off %0d len %0d tot %0d err %0d last %0d",
                             $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                             m_axis_tdata[71:40], m_axis_tdata[103:72],
                             m_axis_tdata[106:104], m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    initial
    begin
        int cyc;
        cyc = 0;
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_cycles > 0)
            begin
                m_axis_tready = 0;
                hold_cycles--;
            end
            else
                case ((cyc / 400) % 4)
                    0: m_axis_tready = 1;
                    1: m_axis_tready = $urandom_range(0, 1);
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = ((cyc % 7) != 3);
                endcase
        end
    end

    task automatic push_row(logic [7:0] b, logic st, logic fin, int n,
                            logic [1:0] k, logic [2:0] code);
        row_t r;
        r = '{b, st, fin, n, k, code};
        row_q.push_back(r);
        stim_q.push_back('{b, st, fin});
    endtask

    task automatic rand_event(ref logic [7:0] trk [$], ref logic [7:0] last_st);
        int nd;
        logic [7:0] s, len;
        nd = ($urandom_range(0, 30) == 0) ? 4 : $urandom_range(0, 3);
        repeat (nd)
            trk.push_back($urandom_range(0, 8'h7F));
        trk.push_back($urandom_range(8'h80, 8'hFF));
        case ($urandom_range(0, 9))
            0, 1:
            begin
                trk.push_back(8'hFF);
                s = $urandom_range(0, 8'hFF);
                if (s == 8'h2F)
                    s = 8'h01;
                len = $urandom_range(0, 3);
                trk.push_back(s);
                trk.push_back(len);
                repeat (len)
                    trk.push_back($urandom_range(0, 8'hFF));
            end
            2:
                if ($urandom_range(0, 5) == 0)
                    trk.push_back($urandom_range(0, 1) ? $urandom_range(0, 8'h7F)
                                                       : $urandom_range(8'hF0, 8'hFE));
                else
                    trk.push_back(8'hC0 | $urandom_range(0, 31));
            default:
            begin
                if ($urandom_range(0, 2) == 0 && last_st != 0)
                    s = last_st;
                else
                    do s = $urandom_range(8'h80, 8'hEF);
                    while (s[7:4] == 4'hF);
                last_st = s;
                trk.push_back(s);
                repeat ((s[7:4] == 4'hC || s[7:4] == 4'hD) ? 1 : 2)
                    trk.push_back($urandom_range(0, 8'hFF));
            end
        endcase
    endtask

    // a clean file declares four tracks and holds three well-formed track chunks, no faults and no cut
    task automatic make_file(input bit clean);
        logic [7:0] f [$];
        logic [7:0] trk [$];
        logic [7:0] last_st;
        logic [31:0] ntrk, len, num;
        int cut;
        if (clean)
            ntrk = 32'd4;
        else
            ntrk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 4);
        if (!clean && $urandom_range(0, 14) == 0)
            ntrk |= 32'hFF01_0000;
        foreach (SIG[i])
            f.push_back(SIG[i]);
        if (!clean && $urandom_range(0, 19) == 0)
            f[$urandom_range(0, 7)] ^= 8'h01 << $urandom_range(0, 7);
        while (f.size() < 'h30)
            f.push_back($urandom_range(0, 8'hFF));
        for (int i = 0; i < 4; i++)
            f.push_back(ntrk[8*i +: 8]);
        while (f.size() < 'h300)
            f.push_back($urandom_range(0, 8'hFF));
        repeat ($urandom_range(0, 6))
            f.push_back($urandom_range(0, 8'hFE));
        f.push_back(8'hFF); f.push_back(8'h2F); f.push_back(8'h00);
        for (int t = 1; t < int'(ntrk[15:0]); t++)
        begin
            trk.delete();
            last_st = 0;
            if (clean || $urandom_range(0, 9) != 0)
            begin
                repeat (clean ? 0 : $urandom_range(0, 6))
                    rand_event(trk, last_st);
                trk.push_back(8'h80);
                trk.push_back(8'hFF);
                trk.push_back(8'h2F);
                trk.push_back((!clean && $urandom_range(0, 24) == 0) ? 8'h01 : 8'h00);
            end
            num = (!clean && $urandom_range(0, 24) == 0) ? t + 1 : t;
            len = 12 + trk.size();
            if (!clean)
                case ($urandom_range(0, 29))
                    0: len = len + 1;
                    1: len = len - 1;
                    2: len = $urandom_range(0, 11);
                    default: ;
                endcase
            for (int i = 0; i < 4; i++)
                f.push_back(num[8*i +: 8]);
            for (int i = 0; i < 4; i++)
                f.push_back(len[8*i +: 8]);
            repeat (4)
                f.push_back($urandom_range(0, 8'hFF));
            foreach (trk[i])
                f.push_back(trk[i]);
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5))
                f.push_back($urandom_range(0, 8'hFF));
        cut = (!clean && $urandom_range(0, 7) == 0) ? $urandom_range(1, f.size()) : f.size();
        for (int i = 0; i < cut; i++)
            stim_q.push_back('{f[i], i == 0, i == cut - 1});
    endtask

    task automatic send_word(hmp_word_t w, ref int burst);
        @(negedge clk);
        if (burst <= 0)
        begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        s_axis_tvalid = 1;
        s_axis_tdata = w.b;
        s_axis_tuser = w.st;
        s_axis_tlast = w.fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst--;
    endtask

    initial
    begin
        int burst, nfile, sent;
        hmp_word_t w;
        clear_state();
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        s_axis_tlast = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        push_row(8'h41, 0, 0, 0, KIND_BYTE, 0);
        push_row(8'h58, 1, 0, 1, KIND_ERROR, ERR_SIGNATURE);
        push_row(8'hFF, 0, 0, 0, KIND_BYTE, 0);
        push_row("H", 1, 1, 1, KIND_ERROR, ERR_TRUNCATED);
        push_row(8'h00, 0, 1, 0, KIND_BYTE, 0);
        push_row("H", 1, 0, 0, KIND_BYTE, 0);
        push_row("M", 0, 0, 0, KIND_BYTE, 0);
        push_row("Q", 0, 0, 1, KIND_ERROR, ERR_SIGNATURE);
        push_row(8'h00, 1, 0, 1, KIND_ERROR, ERR_SIGNATURE);
        push_row("H", 1, 0, 0, KIND_BYTE, 0);
        push_row("M", 1, 0, 1, KIND_ERROR, ERR_SIGNATURE);
        push_row("H", 1, 0, 0, KIND_BYTE, 0);
        push_row("M", 0, 0, 0, KIND_BYTE, 0);
        push_row("I", 0, 1, 1, KIND_ERROR, ERR_TRUNCATED);
        foreach (row_q[i])
            known_q.push_back(row_q[i].known_n);

        burst = 0;
        while (stim_q.size())
        begin
            w = stim_q.pop_front();
            send_word(w, burst);
        end

        for (nfile = 0; nfile < 8; nfile++)
        begin
            make_file(nfile == 2);
            if (nfile == 4)
            begin
                @(negedge clk);
                s_axis_tvalid = 0;
                while (midi_q.size())
                    @(negedge clk);
                repeat (10) @(negedge clk);
            end
            sent = 0;
            while (stim_q.size())
            begin
                w = stim_q.pop_front();
                send_word(w, burst);
                sent++;
                // long receiver stall once the header has been queued
                if (nfile == 2 && sent == 'h301)
                    hold_cycles = 300;
            end
        end
        @(negedge clk);
        s_axis_tvalid = 0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (midi_q.size())
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0 && midi_q.size() == 0)
            $display("** hmp_to_smf_converter: PASSED **");
        else
            $display("** hmp_to_smf_converter: FAILED **");
        $finish;
    end

endmodule
